// ----- sv/dso_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dso_pkg
// Shared widths, codes and types of the depth-sorted object list.
// ----------------------------------------------------------------------------
package dso_pkg;

	localparam int COORD_W   = 20;	// coordinates, 3 fractional bits
	localparam int CNT_W     = 10;	// entry count, read pointer, capacity limit
	localparam int ID_W      = 16;	// entity handle on the ports
	localparam int KEY_W     = 44;	// squared distance, 6 fractional bits
	localparam int D_W       = 23;	// signed axis difference, 1/16 units
	localparam int ABS_W     = 22;	// magnitude of an axis difference
	localparam int SUM_W     = 46;	// sum of three squares, 1/256 units
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0]       op_t;
	typedef logic [1:0]       status_t;
	typedef logic [KEY_W-1:0] key_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_APPEND = 2'd1;
	localparam op_t OP_READ   = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_PAST_END = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT = 2'd3;

	localparam logic [CNT_W-1:0] CAP_LIMIT_RESET = 10'd512;

	// 1e9 units squared with 6 fractional bits
	localparam key_t FAR_KEY = 44'd64000000000;
	localparam key_t KEY_MAX = {KEY_W{1'b1}};

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] entry_count;
		logic [ID_W-1:0]  read_id;
		key_t             read_key;
		logic             last_entry;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/depth_sorted_object_list.sv -----
// Items are handled one at a time; the next beat is taken once the result is handed to the
// output register, and a sorted insert shifts the entries that it passes one place back, one
// entry per cycle, through the entry memory.
// Reset clears the fill count, read pointer and handshakes and restores the configuration
// defaults, not the memory.
`default_nettype none
// ----------------------------------------------------------------------------
// depth_sorted_object_list
// List of transparent objects, sorted far to near by squared view distance on insert
// (append adds at the tail), in one synchronous memory shifted one entry per cycle.
// ----------------------------------------------------------------------------
module depth_sorted_object_list #(
	parameter int CAPACITY = 512,
	parameter int ID_BITS  = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration
	input  wire logic                                  cfg_write,
	input  wire logic [dso_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dso_pkg::CFG_W-1:0]             cfg_data,
	// item channel
	input  wire logic                                  item_valid,
	output logic                                       item_stall,
	input  wire logic [1:0]                            op,
	input  wire logic [dso_pkg::ID_W-1:0]              entity_id,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_min_x,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_min_y,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_min_z,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_max_x,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_max_y,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    box_max_z,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    place_x,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    place_y,
	input  wire logic signed [dso_pkg::COORD_W-1:0]    place_z,
	input  wire logic                                  force_far,
	// result channel
	output logic                                       result_valid,
	input  wire logic                                  result_stall,
	output logic [1:0]                                 status,
	output logic [dso_pkg::CNT_W-1:0]                  entry_count,
	output logic [dso_pkg::ID_W-1:0]                   read_id,
	output logic [dso_pkg::KEY_W-1:0]                  read_key,
	output logic                                       last_entry
);

	// Address width of the entry memory, and the stored handle width (handles are never
	// wider than the port, so bits above it would only ever hold zero).
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int ID_SW = (ID_BITS < dso_pkg::ID_W) ? ID_BITS : dso_pkg::ID_W;
	localparam int MEM_W = ID_SW + dso_pkg::KEY_W;
	localparam int EXT_W = (IDX_W > dso_pkg::CNT_W) ? IDX_W : dso_pkg::CNT_W;

	// State codes of the sequencer.
	localparam logic [2:0] S_IDLE   = 3'd0;	// waiting for a beat
	localparam logic [2:0] S_KEY    = 3'd1;	// three squares through one multiplier
	localparam logic [2:0] S_ROUND  = 3'd2;	// round and saturate, start the scan
	localparam logic [2:0] S_SCAN   = 3'd3;	// move smaller keys one place back
	localparam logic [2:0] S_PLACE  = 3'd4;	// write the new entry
	localparam logic [2:0] S_RDWAIT = 3'd5;	// memory read in flight
	localparam logic [2:0] S_DONE   = 3'd6;	// hand the result to the output register

	// Turns a count into a memory address; counts never reach past the built capacity
	// when they are used as an address.
	function automatic logic [IDX_W-1:0] to_addr(input logic [dso_pkg::CNT_W-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[IDX_W-1:0];
	endfunction

	// Axis difference 2*view - (min + max) - 2*place, exact, in 1/16 units.
	function automatic logic signed [dso_pkg::D_W-1:0] axis_diff(
		input logic signed [dso_pkg::COORD_W-1:0] v,
		input logic signed [dso_pkg::COORD_W-1:0] mn,
		input logic signed [dso_pkg::COORD_W-1:0] mx,
		input logic signed [dso_pkg::COORD_W-1:0] pl
	);
		logic signed [dso_pkg::D_W-1:0] ve;
		logic signed [dso_pkg::D_W-1:0] mne;
		logic signed [dso_pkg::D_W-1:0] mxe;
		logic signed [dso_pkg::D_W-1:0] ple;
		ve  = dso_pkg::D_W'(v);
		mne = dso_pkg::D_W'(mn);
		mxe = dso_pkg::D_W'(mx);
		ple = dso_pkg::D_W'(pl);
		return (ve <<< 1) - (mne + mxe) - (ple <<< 1);
	endfunction

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic signed [dso_pkg::COORD_W-1:0] view_x_q, view_y_q, view_z_q;
	logic [dso_pkg::CNT_W-1:0]          cap_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q    <= '0;
			view_y_q    <= '0;
			view_z_q    <= '0;
			cap_limit_q <= dso_pkg::CAP_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dso_pkg::CFG_VIEW_X:    view_x_q    <= cfg_data;
				dso_pkg::CFG_VIEW_Y:    view_y_q    <= cfg_data;
				dso_pkg::CFG_VIEW_Z:    view_z_q    <= cfg_data;
				dso_pkg::CFG_CAP_LIMIT: cap_limit_q <= cfg_data[dso_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Entry memory: handle in the upper bits, key in the lower bits. One write
	// and one read per cycle, read data registered.
	// ------------------------------------------------------------------------
	logic [MEM_W-1:0] entry_mem [CAPACITY];
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	logic [MEM_W-1:0] mem_wd;
	logic [MEM_W-1:0] mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= entry_mem[mem_ra];
		end
	end

	// ------------------------------------------------------------------------
	// Control and working registers
	// ------------------------------------------------------------------------
	logic [2:0]                          state_q;
	logic [dso_pkg::CNT_W-1:0]           fill_q;
	logic [dso_pkg::CNT_W-1:0]           rp_q;
	logic [dso_pkg::CNT_W-1:0]           pos_q;	// hole where the new entry may go
	logic [2:0]                          cnt_q;	// step of the key pipeline
	dso_pkg::op_t                        op_q;
	logic                                far_q;
	logic [ID_SW-1:0]                    id_q;
	logic signed [dso_pkg::D_W-1:0]      d_q [3];
	logic [dso_pkg::ABS_W-1:0]           absd_q;
	logic [2*dso_pkg::ABS_W-1:0]         prod_q;
	logic [dso_pkg::SUM_W-1:0]           sum_q;
	dso_pkg::key_t                       key_q;
	dso_pkg::result_t                    pend_q;
	dso_pkg::result_t                    res_q;
	logic                                res_valid_q;

	// The list is full once it holds the smaller of the programmed limit and the
	// built capacity.
	logic full;
	assign full = (fill_q >= cap_limit_q) || ({22'd0, fill_q} >= 32'(CAPACITY));

	logic accept;
	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);

	logic read_ok;
	assign read_ok = (rp_q < fill_q);

	// Status and entry count that an accepted beat starts out with.
	dso_pkg::status_t          beat_status;
	logic [dso_pkg::CNT_W-1:0] beat_count;
	always_comb begin
		beat_status = dso_pkg::ST_OK;
		beat_count  = fill_q;
		unique case (op) inside
			dso_pkg::OP_INSERT, dso_pkg::OP_APPEND: begin
				if (full) begin
					beat_status = dso_pkg::ST_FULL;
				end
			end
			dso_pkg::OP_READ: begin
				if (!read_ok) begin
					beat_status = dso_pkg::ST_PAST_END;
				end
			end
			default: beat_count = '0;
		endcase
	end

	// Magnitude of the axis selected by the key step.
	logic signed [dso_pkg::D_W-1:0] d_sel;
	logic [dso_pkg::D_W-1:0]        d_abs;
	always_comb begin
		case (cnt_q)
			3'd0:    d_sel = d_q[0];
			3'd1:    d_sel = d_q[1];
			default: d_sel = d_q[2];
		endcase
		d_abs = d_sel[dso_pkg::D_W-1] ? dso_pkg::D_W'(-d_sel) : dso_pkg::D_W'(d_sel);
	end

	// Round to nearest with halves up, then saturate.
	logic [dso_pkg::SUM_W:0] rounded;
	dso_pkg::key_t           key_sat;
	always_comb begin
		rounded = ((dso_pkg::SUM_W+1)'(sum_q) + (dso_pkg::SUM_W+1)'(2)) >> 2;
		key_sat = (rounded > (dso_pkg::SUM_W+1)'(dso_pkg::KEY_MAX))
			? dso_pkg::KEY_MAX : rounded[dso_pkg::KEY_W-1:0];
	end

	// Fields of the entry just read back.
	dso_pkg::key_t     rd_key;
	logic [ID_SW-1:0]  rd_id;
	logic [dso_pkg::ID_W-1:0] rd_id_ext;
	assign rd_key = mem_rd_q[dso_pkg::KEY_W-1:0];
	assign rd_id  = mem_rd_q[MEM_W-1:dso_pkg::KEY_W];
	always_comb begin
		rd_id_ext              = '0;
		rd_id_ext[ID_SW-1:0]   = rd_id;
	end

	// An entry moves back while its key is strictly smaller than the new one, which
	// places the new entry behind any equal keys.
	logic scan_move;
	assign scan_move = (rd_key < key_q);

	// A sorted insert into a non-empty list starts scanning from the tail.
	logic start_scan;
	assign start_scan = (op_q == dso_pkg::OP_INSERT) && (fill_q != '0);

	// Memory port control, decoded from the sequencer state.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = to_addr(pos_q);
		mem_wd = {id_q, key_q};
		mem_re = 1'b0;
		mem_ra = to_addr(rp_q);
		unique case (state_q)
			S_IDLE: begin
				mem_re = accept && (op == dso_pkg::OP_READ) && read_ok;
			end
			S_ROUND: begin
				mem_re = start_scan;
				mem_ra = to_addr(fill_q - dso_pkg::CNT_W'(1));
			end
			S_SCAN: begin
				if (scan_move) begin
					mem_we = 1'b1;
					mem_wd = mem_rd_q;
					// the next entry up front, unless the hole has reached the head
					mem_re = (pos_q != dso_pkg::CNT_W'(1));
					mem_ra = to_addr(pos_q - dso_pkg::CNT_W'(2));
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			rp_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op) inside
							dso_pkg::OP_INSERT, dso_pkg::OP_APPEND: begin
								state_q <= full ? S_DONE : S_KEY;
							end
							dso_pkg::OP_READ: begin
								state_q <= read_ok ? S_RDWAIT : S_DONE;
							end
							default: begin
								fill_q  <= '0;
								rp_q    <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_KEY: begin
					if (cnt_q == 3'd4) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= start_scan ? S_SCAN : S_PLACE;
				end
				S_SCAN: begin
					if (!scan_move || pos_q == dso_pkg::CNT_W'(1)) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					fill_q  <= fill_q + dso_pkg::CNT_W'(1);
					state_q <= S_DONE;
				end
				S_RDWAIT: begin
					rp_q    <= rp_q + dso_pkg::CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || !result_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= op;
					far_q  <= force_far;
					id_q   <= entity_id[ID_SW-1:0];
					d_q[0] <= axis_diff(view_x_q, box_min_x, box_max_x, place_x);
					d_q[1] <= axis_diff(view_y_q, box_min_y, box_max_y, place_y);
					d_q[2] <= axis_diff(view_z_q, box_min_z, box_max_z, place_z);
					cnt_q  <= '0;
					sum_q  <= '0;
					pend_q <= '{status: beat_status, entry_count: beat_count,
						read_id: '0, read_key: '0, last_entry: 1'b0};
				end
			end
			S_KEY: begin
				// magnitude, square and sum each take a stage; three axes overlap
				cnt_q  <= cnt_q + 3'd1;
				absd_q <= d_abs[dso_pkg::ABS_W-1:0];
				prod_q <= absd_q * absd_q;
				if (cnt_q >= 3'd2) begin
					sum_q <= sum_q + dso_pkg::SUM_W'(prod_q);
				end
			end
			S_ROUND: begin
				key_q <= ((op_q == dso_pkg::OP_INSERT) && far_q) ? dso_pkg::FAR_KEY : key_sat;
				pos_q <= fill_q;
			end
			S_SCAN: begin
				if (scan_move) begin
					pos_q <= pos_q - dso_pkg::CNT_W'(1);
				end
			end
			S_PLACE: begin
				pend_q.entry_count <= fill_q + dso_pkg::CNT_W'(1);
			end
			S_RDWAIT: begin
				pend_q.read_id    <= rd_id_ext;
				pend_q.read_key   <= rd_key;
				pend_q.last_entry <= (rp_q + dso_pkg::CNT_W'(1) == fill_q);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------------
	// Output register: holds one result so that the next beat can be taken
	// while it waits.
	// ------------------------------------------------------------------------
	logic res_load;
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= pend_q;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_q.status;
	assign entry_count  = res_q.entry_count;
	assign read_id      = res_q.read_id;
	assign read_key     = res_q.read_key;
	assign last_entry   = res_q.last_entry;

endmodule
`default_nettype wire

// ----- sv/dso_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dso_checker
// Port-level checks on the depth-sorted object list, bound to the top level.
// ----------------------------------------------------------------------------
module dso_checker #(
	parameter int CAPACITY = 512
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        result_valid,
	input wire logic                        result_stall,
	input wire logic [1:0]                  status,
	input wire logic [dso_pkg::CNT_W-1:0]   entry_count,
	input wire logic [dso_pkg::ID_W-1:0]    read_id,
	input wire logic [dso_pkg::KEY_W-1:0]   read_key,
	input wire logic                        last_entry
);

	// A stalled result stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(entry_count) && $stable(read_id) && $stable(read_key))
		else $error("stalled result changed");

	// Only a successful read carries entry data.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != dso_pkg::ST_OK |->
			read_id == '0 && read_key == '0 && !last_entry)
		else $error("entry data on a failed step");

	// The final entry can only be flagged when the list still holds entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_entry |-> status == dso_pkg::ST_OK && entry_count != '0)
		else $error("last entry flagged on an empty list");

	// The list never grows beyond the built capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> {22'd0, entry_count} <= 32'(CAPACITY))
		else $error("entry count beyond capacity");

endmodule

bind depth_sorted_object_list dso_checker #(.CAPACITY(CAPACITY)) u_dso_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.entry_count  (entry_count),
	.read_id      (read_id),
	.read_key     (read_key),
	.last_entry   (last_entry)
);
`default_nettype wire
